/* rtl/core/mcbrb_pkg.sv */
// Shared types and constants for the multi-channel byte ring buffer.
`timescale 1ns / 1ps

package mcbrb_pkg;

    localparam int KIND_W  = 2;
    localparam int CHAN_W  = 3;
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 6;
    localparam int FILL_W  = 6;

    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [DATA_W-1:0]  t_byte;
    typedef logic [FILL_W-1:0]  t_fill;

    localparam t_kind KIND_WRITE  = 2'd0;
    localparam t_kind KIND_READ   = 2'd1;
    localparam t_kind KIND_PEEK   = 2'd2;
    localparam t_kind KIND_STATUS = 2'd3;

endpackage

/* rtl/core/multi_channel_byte_ring_buffer.sv */
// Multi-channel byte ring buffer: per-channel FIFOs in one shared byte store.
//
// Each word on the input channel writes, pops, peeks or queries one channel FIFO
// of DEPTH slots (at most DEPTH-1 bytes held). A word is taken only when the block
// is idle. The result of a write, a status query, a pop of an empty channel, a
// peek finding no bytes or any word to a channel at or above CHANNELS is set in
// the evaluation state; a pop that finds data also passes a load state, as the
// byte store is read through its single registered read port. A peek finding n
// bytes gives n results, each loaded after the previous one is taken, again paced
// by that read port. The next word is taken in the cycle after the final result
// is taken. Pointers clear at reset; no clearing pass.
`timescale 1ns / 1ps

module multi_channel_byte_ring_buffer
    import mcbrb_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int CHANNELS = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [CHAN_W-1:0]  i_channel,
    input  logic [DATA_W-1:0]  i_wdata,
    input  logic [COUNT_W-1:0] i_peek_count,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [DATA_W-1:0]  o_rdata,
    output logic [FILL_W-1:0]  o_fill,
    output logic               o_is_empty,
    output logic               o_ok,
    output logic               o_last
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;

    t_kind              r_kind;
    logic [CHAN_W-1:0]  r_chan;
    t_byte              r_wdata;
    logic [COUNT_W-1:0] r_count;

    logic [PW-1:0]      r_head [CHANNELS];
    logic [PW-1:0]      r_tail [CHANNELS];
    t_byte              r_mem  [CHANNELS][DEPTH];

    logic [PW-1:0]      r_rd_ptr;
    logic [COUNT_W-1:0] r_left;
    t_fill              r_peek_n;
    t_fill              r_peek_fill;

    logic               r_out_valid;
    t_byte              r_rdata;
    t_fill              r_fill;
    logic               r_is_empty;
    logic               r_ok;
    logic               r_last;

    logic [CW-1:0]      ch_idx;
    logic               chan_ok;
    logic [PW-1:0]      head;
    logic [PW-1:0]      tail;
    logic [PW-1:0]      head_nx;
    logic [PW-1:0]      tail_nx;
    logic [PW:0]        diff;
    logic [PW-1:0]      cur_fill;
    t_fill              fill6;
    logic               full;
    logic               empty;
    t_fill              peek_n;
    logic               in_accept;
    logic               do_write;

    function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p);
        step_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // shared pointer arithmetic for the addressed channel
    assign ch_idx   = CW'(r_chan);
    assign chan_ok  = ({2'b00, r_chan} < 5'(CHANNELS));
    assign head     = r_head[ch_idx];
    assign tail     = r_tail[ch_idx];
    assign head_nx  = step_ptr(head);
    assign tail_nx  = step_ptr(tail);
    assign diff     = {1'b0, tail} - {1'b0, head};
    assign cur_fill = diff[PW] ? PW'(diff + (PW+1)'(DEPTH)) : diff[PW-1:0];
    assign fill6    = FILL_W'(cur_fill);
    assign full     = (tail_nx == head);
    assign empty    = (head == tail);
    assign peek_n   = (r_count >= fill6) ? fill6 : r_count;

    assign in_accept = i_in_valid && !o_in_stall;
    assign do_write  = (r_state == S_EVAL) && chan_ok && (r_kind == KIND_WRITE) && !full;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (chan_ok && (((r_kind == KIND_READ) && !empty) ||
                                ((r_kind == KIND_PEEK) && (peek_n != '0)))) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_LOAD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = r_last ? S_IDLE : S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_kind  <= i_kind;
                        r_chan  <= i_channel;
                        r_wdata <= i_wdata;
                        r_count <= i_peek_count;
                    end
                end
                S_EVAL: begin
                    r_last <= 1'b1;
                    if (!chan_ok) begin
                        r_fill      <= '0;
                        r_is_empty  <= 1'b1;
                        r_ok        <= 1'b0;
                        r_out_valid <= 1'b1;
                    end else begin
                        case (r_kind)
                            KIND_WRITE: begin
                                if (!full) begin
                                    r_tail[ch_idx] <= tail_nx;
                                end
                                r_fill      <= full ? fill6 : fill6 + FILL_W'(1);
                                r_is_empty  <= full && empty;
                                r_ok        <= !full;
                                r_out_valid <= 1'b1;
                            end
                            KIND_READ: begin
                                if (!empty) begin
                                    r_head[ch_idx] <= head_nx;
                                end
                                r_rd_ptr    <= head;
                                r_left      <= COUNT_W'(1);
                                r_fill      <= empty ? '0 : fill6 - FILL_W'(1);
                                r_is_empty  <= empty || (fill6 == FILL_W'(1));
                                r_ok        <= !empty;
                                r_out_valid <= empty;
                            end
                            KIND_PEEK: begin
                                r_rd_ptr    <= head;
                                r_left      <= peek_n;
                                r_peek_n    <= peek_n;
                                r_peek_fill <= fill6;
                                r_fill      <= '0;
                                r_is_empty  <= empty;
                                r_ok        <= (peek_n != '0);
                                r_out_valid <= (peek_n == '0);
                            end
                            KIND_STATUS: begin
                                r_fill      <= fill6;
                                r_is_empty  <= empty;
                                r_ok        <= 1'b0;
                                r_out_valid <= 1'b1;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_LOAD: begin
                    r_out_valid <= 1'b1;
                    r_rd_ptr    <= step_ptr(r_rd_ptr);
                    r_left      <= r_left - COUNT_W'(1);
                    if (r_kind == KIND_PEEK) begin
                        r_last <= (r_left == COUNT_W'(1));
                        r_fill <= (r_left == COUNT_W'(1)) ? r_peek_n : r_peek_fill;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    // byte store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[ch_idx][tail] <= r_wdata;
        end
        if (r_state == S_LOAD) begin
            r_rdata <= r_mem[ch_idx][r_rd_ptr];
        end else if (r_state == S_EVAL) begin
            r_rdata <= '0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_rdata     = r_rdata;
    assign o_fill      = r_fill;
    assign o_is_empty  = r_is_empty;
    assign o_ok        = r_ok;
    assign o_last      = r_last;

endmodule

/* rtl/core/mcbrb_checker.sv */
// Port-level checks for the multi-channel byte ring buffer, bound to the top level.
`timescale 1ns / 1ps

module mcbrb_checker
    import mcbrb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [DATA_W-1:0] o_rdata,
    input logic              o_is_empty,
    input logic              o_ok,
    input logic              o_last
);

    // no new word while a result is pending
    a_stall_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("word accepted while a result is pending");

    // result never appears the cycle after a word is taken
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !o_out_valid)
        else $error("result one cycle after acceptance");

    // drops, empty reads and status results are always final
    a_fail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> o_last)
        else $error("failed result not marked last");

    // a non-final peek byte comes from a non-empty channel
    a_peek_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_ok && !o_is_empty))
        else $error("non-final result from empty channel");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_rdata)))
        else $error("stalled result changed");

endmodule

bind multi_channel_byte_ring_buffer mcbrb_checker u_mcbrb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_rdata     (o_rdata),
    .o_is_empty  (o_is_empty),
    .o_ok        (o_ok),
    .o_last      (o_last)
);
